// ===== sv/pse_pkg.sv =====
package pse_pkg;

    // Operand stack geometry.
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int OP_W        = 3;

    // Token codes. The remaining code is treated like a bad token.
    localparam logic [OP_W-1:0] OP_NUMBER = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd1;
    localparam logic [OP_W-1:0] OP_SUB    = 3'd2;
    localparam logic [OP_W-1:0] OP_MUL    = 3'd3;
    localparam logic [OP_W-1:0] OP_DIV    = 3'd4;
    localparam logic [OP_W-1:0] OP_BAD    = 3'd5;
    localparam logic [OP_W-1:0] OP_END    = 3'd6;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] number;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     error;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic            push;
        logic            finish;
        logic            set_err;
        logic            alu_wr;
        logic            div_start;
        logic            div_wr;
        logic [OP_W-1:0] alu_op;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic full;
        logic few;
        logic err_seen;
        logic b_zero;
        logic div_done;
        logic out_busy;
    } dp_status_t;

endpackage

// ===== sv/postfix_stack_evaluator_top.sv =====
// A result appears on the result port in the cycle after its end token is accepted.
// Number, end, bad and ignored tokens need no extra controller state; add, subtract and
// multiply first read the stack RAM and then execute; divide runs the 32-step restoring
// divider, one quotient bit per cycle, unless the divisor is zero, which sets the error.
// Reset (rst_n, asynchronous, active low) clears the controller, the operand count, the
// error flag and the result valid; the stack RAM is not cleared and needs no clearing pass.
module postfix_stack_evaluator_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                token_valid,
    output logic                token_stall,
    input  pse_pkg::in_item_t   token,
    output logic                result_valid,
    input  logic                result_stall,
    output pse_pkg::out_item_t  result
);

    import pse_pkg::*;

    // The controller decodes each token transaction and sequences multi-cycle operators,
    // while the datapath owns the stack, the ALU, the divider and the result register.
    // The two are joined only by the command and status structs below.
    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // A token transaction is refused while an operator is executing, or while a finished
    // result still waits in the output register and the consumer is stalling it. Otherwise
    // new tokens keep flowing while the result register is occupied.
    pse_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_op     (token.op),
        .token_stall  (token_stall),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // The top of stack is held in a register so that every operator needs only one RAM
    // read, for the operand below it. The result register holds the value and error flag
    // of the last end token until the result transaction completes.
    pse_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .number       (token.number),
        .cmd          (cmd),
        .sts          (sts),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sv/pse_ram.sv =====
module pse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/pse_div.sv =====
module pse_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pse_pkg::DATA_W-1:0] dividend,
    input  logic [pse_pkg::DATA_W-1:0] divisor,
    output logic                       done,
    output logic [pse_pkg::DATA_W-1:0] quotient
);

    import pse_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;

    logic [DATA_W-1:0] dividend_mag;
    logic [DATA_W-1:0] divisor_mag;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;

    // Magnitudes; the most negative value maps onto its own unsigned magnitude.
    assign dividend_mag = dividend[DATA_W-1] ? (~dividend + DATA_W'(1)) : dividend;
    assign divisor_mag  = divisor[DATA_W-1]  ? (~divisor + DATA_W'(1))  : divisor;

    // One restoring step: shift in the next dividend bit and try to subtract.
    assign trial = {rem_reg, quo_reg[DATA_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend_mag;
            den_reg <= divisor_mag;
            rem_reg <= '0;
            neg_reg <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[DATA_W])
            begin
                rem_reg <= diff[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DATA_W-1:0];
                quo_reg <= {quo_reg[DATA_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (~quo_reg + DATA_W'(1)) : quo_reg;

endmodule

// ===== sv/pse_ctrl.sv =====
module pse_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     token_valid,
    input  logic [pse_pkg::OP_W-1:0] token_op,
    output logic                     token_stall,
    input  logic                     result_stall,
    input  pse_pkg::dp_status_t      sts,
    output pse_pkg::ctrl_cmd_t       cmd
);

    import pse_pkg::*;

    state_t          state_reg;
    state_t          state_next;
    logic [OP_W-1:0] op_reg;
    logic            accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= token_op;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.alu_op  = op_reg;
        token_stall = (state_reg != ST_IDLE) || (sts.out_busy && result_stall);
        accept      = token_valid && !token_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (token_op == OP_END)
                    begin
                        cmd.finish = 1'b1;
                    end
                    else if (!sts.err_seen)
                    begin
                        case (token_op) inside
                            OP_NUMBER:
                            begin
                                if (sts.full)
                                begin
                                    cmd.set_err = 1'b1;
                                end
                                else
                                begin
                                    cmd.push = 1'b1;
                                end
                            end
                            [OP_ADD:OP_DIV]:
                            begin
                                if (sts.few)
                                begin
                                    cmd.set_err = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_EXEC;
                                end
                            end
                            default:
                            begin
                                cmd.set_err = 1'b1;
                            end
                        endcase
                    end
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                if (op_reg == OP_DIV)
                begin
                    if (sts.b_zero)
                    begin
                        cmd.set_err = 1'b1;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else
                begin
                    cmd.alu_wr = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/pse_datapath.sv =====
module pse_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pse_pkg::DATA_W-1:0] number,
    input  pse_pkg::ctrl_cmd_t         cmd,
    output pse_pkg::dp_status_t        sts,
    input  logic                       result_stall,
    output logic                       result_valid,
    output pse_pkg::out_item_t         result
);

    import pse_pkg::*;

    // The top of stack lives in tos_reg; the entries below it live in the RAM.
    logic [CNT_W-1:0]  count_reg;
    logic              err_reg;
    logic [DATA_W-1:0] tos_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  cnt_m2;
    logic [DATA_W-1:0] second;
    logic [DATA_W-1:0] alu_res;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;

    assign cnt_m1 = count_reg - CNT_W'(1);
    assign cnt_m2 = count_reg - CNT_W'(2);

    pse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (cmd.push && (count_reg != '0)),
        .waddr (cnt_m1[ADDR_W-1:0]),
        .wdata (tos_reg),
        .raddr (cnt_m2[ADDR_W-1:0]),
        .rdata (second)
    );

    pse_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (second),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Second-from-top op top.
    always_comb
    begin
        case (cmd.alu_op)
            OP_SUB:  alu_res = second - tos_reg;
            OP_MUL:  alu_res = second * tos_reg;
            default: alu_res = second + tos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.push)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.alu_wr || cmd.div_wr)
            begin
                count_reg <= cnt_m1;
            end
            if (cmd.set_err)
            begin
                err_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                count_reg     <= '0;
                err_reg       <= 1'b0;
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            tos_reg <= number;
        end
        else if (cmd.alu_wr)
        begin
            tos_reg <= alu_res;
        end
        else if (cmd.div_wr)
        begin
            tos_reg <= div_quo;
        end
        if (cmd.finish)
        begin
            if (err_reg || (count_reg != CNT_W'(1)))
            begin
                out_data_reg.value <= '0;
                out_data_reg.error <= 1'b1;
            end
            else
            begin
                out_data_reg.value <= tos_reg;
                out_data_reg.error <= 1'b0;
            end
        end
    end

    assign sts.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign sts.few      = (count_reg < CNT_W'(2));
    assign sts.err_seen = err_reg;
    assign sts.b_zero   = (tos_reg == '0);
    assign sts.div_done = div_done;
    assign sts.out_busy = out_valid_reg;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("operand count exceeds the stack depth");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (count_reg < CNT_W'(STACK_DEPTH)))
        else $error("push issued into a full stack");

    a_reduce_operands: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.alu_wr || cmd.div_wr) |-> (count_reg >= CNT_W'(2)))
        else $error("operator result written with fewer than two operands");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid_reg && (count_reg == '0) && !err_reg))
        else $error("end transaction did not post a result and clear the stack");

endmodule

// ===== test/postfix_stack_evaluator_checker.sv =====
`timescale 1ns / 100ps

module postfix_stack_evaluator_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               token_valid,
    input  logic               token_stall,
    input  pse_pkg::in_item_t  token,
    input  logic               result_valid,
    input  logic               result_stall,
    input  pse_pkg::out_item_t result,
    output int                 error_count,
    output int                 pending_results
);

    import pse_pkg::*;

    // Shadow copy of the evaluator: operand stack, operand count and sticky flag.
    logic [DATA_W-1:0] operand_copy [STACK_DEPTH];
    int                operands_held;
    bit                expr_failed;
    out_item_t         expected_results [$];
    int                mismatches;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    task automatic push_operand(input logic [DATA_W-1:0] v);
        if (operands_held >= STACK_DEPTH)
        begin
            expr_failed = 1'b1;
        end
        else
        begin
            operand_copy[operands_held] = v;
            operands_held++;
        end
    endtask

    // Applies one accepted token; an end token queues the result it must produce.
    task automatic evaluate_token(input in_item_t t);
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] res;
        longint            quotient;
        out_item_t         r;
        if (t.op == OP_END)
        begin
            r.error = expr_failed || (operands_held != 1);
            r.value = r.error ? '0 : operand_copy[0];
            expected_results = {expected_results, r};
            operands_held = 0;
            expr_failed   = 1'b0;
        end
        else if (!expr_failed)
        begin
            case (t.op) inside
                OP_NUMBER: push_operand(t.number);
                [OP_ADD:OP_DIV]:
                begin
                    if (operands_held < 2)
                    begin
                        expr_failed = 1'b1;
                    end
                    else
                    begin
                        lhs = operand_copy[operands_held - 2];
                        rhs = operand_copy[operands_held - 1];
                        if (t.op == OP_DIV && rhs == '0)
                        begin
                            expr_failed = 1'b1;
                        end
                        else
                        begin
                            case (t.op)
                                OP_ADD: res = lhs + rhs;
                                OP_SUB: res = lhs - rhs;
                                OP_MUL: res = lhs * rhs;
                                default:
                                begin
                                    // Widening makes the most negative value over minus one wrap.
                                    quotient = longint'(signed'(lhs)) / longint'(signed'(rhs));
                                    res      = quotient[DATA_W-1:0];
                                end
                            endcase
                            operands_held -= 2;
                            push_operand(res);
                        end
                    end
                end
                default: expr_failed = 1'b1;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            operands_held = 0;
            expr_failed   = 1'b0;
            mismatches    = 0;
            expected_results.delete();
            error_count     <= 0;
            pending_results <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result: value %0d error %0b",
                                              result.value, result.error));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.value !== want.value || result.error !== want.error)
                    begin
                        report_mismatch($sformatf(
                            "result mismatch: expected value %0d error %0b, got value %0d error %0b",
                            want.value, want.error, result.value, result.error));
                    end
                end
            end
            if (token_valid && !token_stall)
            begin
                evaluate_token(token);
            end
            error_count     <= mismatches;
            pending_results <= expected_results.size();
        end
    end

endmodule

// ===== test/tb_postfix_stack_evaluator_top.sv =====
`timescale 1ns / 100ps

module tb_postfix_stack_evaluator_top;
    import pse_pkg::*;

    localparam logic signed [DATA_W-1:0] MOST_POSITIVE = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MOST_NEGATIVE = 32'sh8000_0000;
    // Random stimulus stops once this many tokens have been accepted.
    localparam int TOKEN_TARGET = 1600;
    // The receiver's long hold-off starts after this many accepted tokens.
    localparam int HOLD_AT_TOKEN = 800;
    localparam int HOLD_CYCLES = 400;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      token_valid = 1'b0;
    logic      token_stall;
    in_item_t  token = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;
    int        error_count;
    int        pending_results;

    // Sender bookkeeping: accepted tokens and the remainder of the current burst.
    int token_count = 0;
    int burst_left = 0;
    // Handshake between the sender and the receiver's long hold-off.
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;

    logic [OP_W-1:0] arith_ops [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};

    // 20 ns clock period.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    postfix_stack_evaluator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .token_valid  (token_valid),
        .token_stall  (token_stall),
        .token        (token),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // The checker watches both channels, predicts every result and counts mismatches.
    postfix_stack_evaluator_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .token_valid     (token_valid),
        .token_stall     (token_stall),
        .token           (token),
        .result_valid    (result_valid),
        .result_stall    (result_stall),
        .result          (result),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    function automatic in_item_t make_token(input logic [OP_W-1:0] op,
                                            input logic signed [DATA_W-1:0] num);
        in_item_t t;
        t.op     = op;
        t.number = num;
        return t;
    endfunction

    // Operand values lean on zero, small magnitudes and the extremes, since those are
    // where division by zero, truncation and wrap-around show up.
    function automatic logic signed [DATA_W-1:0] pick_number();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = '0;
            1:
            begin
                v = $urandom_range(0, 20);
                v = v - 10;
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: v = MOST_POSITIVE;
                    1: v = MOST_NEGATIVE;
                    2: v = -1;
                    default: v = 1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Offers one token and returns once it has been accepted. Tokens go out in bursts
    // of random length, and each burst may be preceded by a gap with valid low.
    task automatic send_token(input in_item_t t);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap)
            begin
                @(negedge clk);
                token_valid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        token_valid <= 1'b1;
        token       <= t;
        @(posedge clk);
        while (token_stall) @(posedge clk);
        token_count++;
        if (token_count == HOLD_AT_TOKEN)
        begin
            hold_request = 1'b1;
        end
    endtask

    // Sends one expression followed by its end token. Most expressions are well formed,
    // so they exercise the arithmetic rather than stopping at the first error. The rest
    // are random noise, lone end tokens, and pushes that fill the stack or overrun it.
    task automatic send_expression();
        int mode;
        int depth;
        int pushes_left;
        in_item_t t;
        mode = $urandom_range(0, 99);
        if (mode < 8)
        begin
            repeat ($urandom_range(1, 6))
            begin
                send_token(make_token(OP_W'($urandom_range(0, 2**OP_W - 1)), $urandom));
            end
        end
        else if (mode < 11)
        begin
            // Nothing but the end token: an empty expression.
        end
        else if (mode < 19)
        begin
            // Fill the stack to one short of the brim, to the brim, or one or two past it, then fold it back down.
            depth = $urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 2);
            repeat (depth)
            begin
                send_token(make_token(OP_NUMBER, pick_number()));
            end
            repeat (depth - 1)
            begin
                send_token(make_token(arith_ops[$urandom_range(0, 2)], '0));
            end
        end
        else
        begin
            depth = 0;
            pushes_left = $urandom_range(1, 8);
            while (pushes_left > 0 || depth > 1)
            begin
                if (depth >= 2 && (pushes_left == 0 || $urandom_range(0, 1) == 1))
                begin
                    t = make_token(arith_ops[$urandom_range(0, 3)], $urandom);
                    depth--;
                end
                else
                begin
                    t = make_token(OP_NUMBER, pick_number());
                    pushes_left--;
                    depth++;
                end
                // Now and then a token is corrupted, which breaks the expression.
                if ($urandom_range(0, 29) == 0)
                begin
                    t.op = OP_W'($urandom_range(0, 2**OP_W - 1));
                end
                send_token(t);
            end
        end
        send_token(make_token(OP_END, $urandom));
    endtask

    // Receiver: stalls on patterns of random length that alternate between no stall,
    // light stall and heavy stall. Once, when the sender asks for it, the result port is
    // held off for a long stretch so that the block backs up and stalls its input.
    initial
    begin
        int stall_mode;
        int pattern_left;
        stall_mode = 0;
        pattern_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                hold_taken = 1'b1;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    stall_mode = $urandom_range(0, 2);
                    pattern_left = $urandom_range(10, 80);
                end
                pattern_left--;
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    default: result_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    // Main stimulus: reset, a short directed part, random expressions, then the verdict.
    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Addition wraps from the most positive value to the most negative.
        send_token(make_token(OP_NUMBER, MOST_POSITIVE));
        send_token(make_token(OP_NUMBER, 1));
        send_token(make_token(OP_ADD, '0));
        send_token(make_token(OP_END, '0));
        // The most negative value divided by minus one wraps back to itself.
        send_token(make_token(OP_NUMBER, MOST_NEGATIVE));
        send_token(make_token(OP_NUMBER, -1));
        send_token(make_token(OP_DIV, '0));
        send_token(make_token(OP_END, '0));
        // Division by zero.
        send_token(make_token(OP_NUMBER, 7));
        send_token(make_token(OP_NUMBER, 0));
        send_token(make_token(OP_DIV, '0));
        send_token(make_token(OP_END, '0));
        // An operator on an empty stack, then an end token with nothing on the stack.
        send_token(make_token(OP_ADD, '0));
        send_token(make_token(OP_END, '0));
        send_token(make_token(OP_END, '0));
        // A bad token poisons the expression, and the push after it is ignored.
        send_token(make_token(OP_BAD, '0));
        send_token(make_token(OP_NUMBER, 5));
        send_token(make_token(OP_END, '0));
        // The unused op code behaves like a bad token.
        send_token(make_token('1, '1));
        send_token(make_token(OP_END, '0));
        // Division truncates toward zero, then a multiply and a subtract:
        // (-7 / 2) * 3 - 10 gives -19.
        send_token(make_token(OP_NUMBER, -7));
        send_token(make_token(OP_NUMBER, 2));
        send_token(make_token(OP_DIV, '0));
        send_token(make_token(OP_NUMBER, 3));
        send_token(make_token(OP_MUL, '0));
        send_token(make_token(OP_NUMBER, 10));
        send_token(make_token(OP_SUB, '0));
        send_token(make_token(OP_END, '0));

        while (token_count < TOKEN_TARGET)
        begin
            send_expression();
        end
        @(negedge clk);
        token_valid <= 1'b0;

        // Drain every outstanding result, then allow for a full divide in flight.
        wait (pending_results == 0);
        repeat (50) @(posedge clk);

        if (error_count == 0 && pending_results == 0)
        begin
            $display("postfix_stack_evaluator_top test passed");
        end
        else
        begin
            $display("postfix_stack_evaluator_top test failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial
    begin
        #20_000_000;
        $display("postfix_stack_evaluator_top test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/pse_pkg.sv
sv/pse_ram.sv
sv/pse_div.sv
sv/pse_ctrl.sv
sv/pse_datapath.sv
sv/postfix_stack_evaluator_top.sv
test/postfix_stack_evaluator_checker.sv
test/tb_postfix_stack_evaluator_top.sv
